### src/atm_pkg.sv
// ----------------------------------------------------------------------------
// atm_pkg
// shared widths, queue entry type and the cordic arctangent table
// ----------------------------------------------------------------------------
package atm_pkg;

    localparam int RAW_W        = 16;
    localparam int SQ_W         = 31;   // square of a 16-bit signed count
    localparam int RAD_W        = 48;   // radicand into the root pipeline
    localparam int ROOT_W       = 25;   // rounded root, one bit of headroom
    localparam int RES_W        = 24;   // truncated root bits, one per stage
    localparam int REM_W        = 26;
    localparam int X_W          = 27;   // cordic x and y
    localparam int Z_W          = 25;   // cordic angle, degrees with 16 fraction bits
    localparam int Z_FRAC       = 16;
    localparam int ANG_W        = 16;
    localparam int MAG_W        = 19;
    localparam int RANGE_W      = 2;
    localparam int NUM_SHIFT    = 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int ATAN_LEN     = 24;
    localparam int DEF_CORDIC_STEPS    = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 8;

    typedef struct packed {
        logic [SQ_W-1:0]         sq_x;
        logic [SQ_W-1:0]         sq_y;
        logic [SQ_W-1:0]         sq_z;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
    } atm_entry_t;

    // round(atan(2^-i) degrees * 2^16)
    function automatic logic signed [Z_W-1:0] atm_atan(input int i);
        logic signed [Z_W-1:0] t;
        case (i)
            0:  t = 25'sd2949120;
            1:  t = 25'sd1740967;
            2:  t = 25'sd919879;
            3:  t = 25'sd466945;
            4:  t = 25'sd234379;
            5:  t = 25'sd117304;
            6:  t = 25'sd58666;
            7:  t = 25'sd29335;
            8:  t = 25'sd14668;
            9:  t = 25'sd7334;
            10: t = 25'sd3667;
            11: t = 25'sd1833;
            12: t = 25'sd917;
            13: t = 25'sd458;
            14: t = 25'sd229;
            15: t = 25'sd115;
            16: t = 25'sd57;
            17: t = 25'sd29;
            18: t = 25'sd14;
            19: t = 25'sd7;
            20: t = 25'sd4;
            21: t = 25'sd2;
            22: t = 25'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

### src/accel_tilt_and_magnitude_unit.sv
// ----------------------------------------------------------------------------
// accel_tilt_and_magnitude_unit
// roll, pitch and magnitude from one raw three-axis accelerometer sample
// ----------------------------------------------------------------------------
// Takes one sample per clock and returns one result per clock when pop keeps
// up. A sample is written into the squaring queue at its accepting edge and
// moves into the prep register at the next edge at the earliest, then passes
// the pipelined square roots (one root bit per stage plus rounding), the
// pipelined cordic (one rotation per stage) and the result register.
// Once a result waits in the result register and pop is low, the whole
// pipeline freezes and the four-entry input queue fills before full rises.
// The range register only scales the magnitude and should be written while
// no sample is in flight.
module accel_tilt_and_magnitude_unit
#(
    parameter int CORDIC_STEPS    = atm_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = atm_pkg::DEF_ANGLE_FRAC_BITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [atm_pkg::RANGE_W-1:0]        cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic signed [atm_pkg::RAW_W-1:0]   raw_x,
    input  logic signed [atm_pkg::RAW_W-1:0]   raw_y,
    input  logic signed [atm_pkg::RAW_W-1:0]   raw_z,
    input  logic                               pop,
    output logic                               empty,
    output logic signed [atm_pkg::ANG_W-1:0]   roll_deg,
    output logic signed [atm_pkg::ANG_W-1:0]   pitch_deg,
    output logic [atm_pkg::MAG_W-1:0]          accel_magnitude
);
    import atm_pkg::*;

    logic [RANGE_W-1:0] range_reg;
    logic               q_pop, q_empty;
    atm_entry_t         q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= '0;
        end
        else if (cfg_we)
        begin
            range_reg <= cfg_data;
        end
    end

    atm_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .raw_x   (raw_x),
        .raw_y   (raw_y),
        .raw_z   (raw_z),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    atm_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .range_sel       (range_reg),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .roll_deg        (roll_deg),
        .pitch_deg       (pitch_deg),
        .accel_magnitude (accel_magnitude)
    );

endmodule

### src/atm_front.sv
// ----------------------------------------------------------------------------
// atm_front
// takes samples, squares the axes and holds them in a short queue
// ----------------------------------------------------------------------------
module atm_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic signed [atm_pkg::RAW_W-1:0] raw_x,
    input  logic signed [atm_pkg::RAW_W-1:0] raw_y,
    input  logic signed [atm_pkg::RAW_W-1:0] raw_z,
    input  logic                           q_pop,
    output logic                           q_empty,
    output atm_pkg::atm_entry_t            q_head
);
    import atm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    atm_entry_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;
    logic signed [2*RAW_W-1:0] px, py, pz;
    atm_entry_t         wr_entry;
    logic               do_push, do_pop;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && !q_empty;

    always_comb
    begin
        px = raw_x * raw_x;
        py = raw_y * raw_y;
        pz = raw_z * raw_z;
        wr_entry.sq_x  = px[SQ_W-1:0];
        wr_entry.sq_y  = py[SQ_W-1:0];
        wr_entry.sq_z  = pz[SQ_W-1:0];
        wr_entry.raw_x = raw_x;
        wr_entry.raw_y = raw_y;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### src/atm_sqrt.sv
// ----------------------------------------------------------------------------
// atm_sqrt
// pipelined square root, one result bit per stage, rounded to nearest
// ----------------------------------------------------------------------------
module atm_sqrt
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [atm_pkg::RAD_W-1:0]    rad,
    output logic [atm_pkg::ROOT_W-1:0]   root
);
    import atm_pkg::*;

    localparam int STAGES = RES_W;
    localparam int CUR_W  = REM_W + 2;

    logic [RAD_W-1:0] rad_reg  [STAGES-1];
    logic [REM_W-1:0] rem_reg  [STAGES];
    logic [RES_W-1:0] res_reg  [STAGES];
    logic [ROOT_W-1:0] root_reg;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic [RAD_W-1:0] rad_in;
            logic [REM_W-1:0] rem_in;
            logic [RES_W-1:0] res_in;
            logic [CUR_W-1:0] cur, trial;

            if (k == 0)
            begin : g_first
                assign rad_in = rad;
                assign rem_in = '0;
                assign res_in = '0;
            end
            else
            begin : g_next
                assign rad_in = rad_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign res_in = res_reg[k-1];
            end

            assign cur   = {rem_in, rad_in[RAD_W-1-2*k -: 2]};
            assign trial = {2'b00, res_in, 2'b01};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (cur >= trial)
                    begin
                        rem_reg[k] <= REM_W'(cur - trial);
                        res_reg[k] <= {res_in[RES_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k] <= REM_W'(cur);
                        res_reg[k] <= {res_in[RES_W-2:0], 1'b0};
                    end
                end
            end

            if (k < STAGES - 1)
            begin : g_rad
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rad_reg[k] <= rad_in;
                    end
                end
            end
        end
    endgenerate

    // remainder above the root means the value lies past the half point
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_reg[STAGES-1] > REM_W'(res_reg[STAGES-1]))
            begin
                root_reg <= ROOT_W'(res_reg[STAGES-1]) + 1'b1;
            end
            else
            begin
                root_reg <= ROOT_W'(res_reg[STAGES-1]);
            end
        end
    end

    assign root = root_reg;

endmodule

### src/atm_cordic.sv
// ----------------------------------------------------------------------------
// atm_cordic
// pipelined vectoring cordic, one rotation per stage
// ----------------------------------------------------------------------------
module atm_cordic
#(
    parameter int CORDIC_STEPS = atm_pkg::DEF_CORDIC_STEPS
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic [atm_pkg::ROOT_W-1:0]        den,
    input  logic signed [atm_pkg::RAW_W-1:0]  num,
    output logic signed [atm_pkg::Z_W-1:0]    angle,
    output logic                              zero
);
    import atm_pkg::*;

    logic signed [X_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [X_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0] z_reg [CORDIC_STEPS];
    logic                  zero_reg [CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            logic signed [X_W-1:0] x_in, y_in, xs, ys;
            logic signed [Z_W-1:0] z_in;
            logic                  zero_in;

            if (i == 0)
            begin : g_first
                assign x_in    = X_W'($signed({1'b0, den}));
                assign y_in    = X_W'(num) <<< NUM_SHIFT;
                assign z_in    = '0;
                assign zero_in = (den == '0) && (num == '0);
            end
            else
            begin : g_next
                assign x_in    = x_reg[i-1];
                assign y_in    = y_reg[i-1];
                assign z_in    = z_reg[i-1];
                assign zero_in = zero_reg[i-1];
            end

            assign xs = x_in >>> i;
            assign ys = y_in >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i] <= zero_in;
                    if (!y_in[X_W-1])
                    begin
                        x_reg[i] <= x_in + ys;
                        y_reg[i] <= y_in - xs;
                        z_reg[i] <= z_in + atm_atan(i);
                    end
                    else
                    begin
                        x_reg[i] <= x_in - ys;
                        y_reg[i] <= y_in + xs;
                        z_reg[i] <= z_in - atm_atan(i);
                    end
                end
            end
        end
    endgenerate

    assign angle = z_reg[CORDIC_STEPS-1];
    assign zero  = zero_reg[CORDIC_STEPS-1];

endmodule

### src/atm_back.sv
// ----------------------------------------------------------------------------
// atm_back
// root and cordic pipeline with the result register
// ----------------------------------------------------------------------------
module atm_back
#(
    parameter int CORDIC_STEPS    = atm_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = atm_pkg::DEF_ANGLE_FRAC_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [atm_pkg::RANGE_W-1:0]          range_sel,
    input  logic                                 q_empty,
    input  atm_pkg::atm_entry_t                  q_head,
    output logic                                 q_pop,
    input  logic                                 pop,
    output logic                                 empty,
    output logic signed [atm_pkg::ANG_W-1:0]     roll_deg,
    output logic signed [atm_pkg::ANG_W-1:0]     pitch_deg,
    output logic [atm_pkg::MAG_W-1:0]            accel_magnitude
);
    import atm_pkg::*;

    localparam int SQRT_LAT = RES_W + 1;
    localparam int PIPE_LEN = 1 + SQRT_LAT + CORDIC_STEPS;
    localparam int SH       = Z_FRAC - ANGLE_FRAC_BITS;
    localparam int LIM      = 90 << ANGLE_FRAC_BITS;
    localparam int POS_LIM  = (LIM > 32767) ? 32767 : LIM;
    localparam int NEG_LIM  = (LIM > 32768) ? 32768 : LIM;
    localparam int ZR_W     = Z_W + 1;
    localparam int MAG_MAX  = (1 << MAG_W) - 1;

    logic                     adv;
    logic                     vld_reg [PIPE_LEN];
    logic [RAD_W-1:0]         rad_roll_reg, rad_pitch_reg, rad_mag_reg;
    logic signed [RAW_W-1:0]  num_roll_reg [SQRT_LAT + 1];
    logic signed [RAW_W-1:0]  num_pitch_reg [SQRT_LAT + 1];
    logic [ROOT_W-1:0]        den_roll, den_pitch, mag_root;
    logic [ROOT_W-1:0]        mag_dly_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]    z_roll, z_pitch;
    logic                     zero_roll, zero_pitch;
    logic [SQ_W:0]            sum_roll, sum_pitch;
    logic [SQ_W+1:0]          sum_all;
    logic                     out_valid_reg;
    logic signed [ANG_W-1:0]  roll_reg, pitch_reg, roll_next, pitch_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;

    // the whole pipeline moves while the result register can take a beat
    assign adv   = !out_valid_reg || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !out_valid_reg;

    function automatic logic signed [ANG_W-1:0] finish_angle(
        input logic signed [Z_W-1:0] z, input logic zero_flag);
        logic signed [ZR_W-1:0] zr;
        logic signed [ZR_W-1:0] r;
        logic signed [ANG_W-1:0] res;
        zr = ZR_W'(z) + ZR_W'(1 << (SH - 1));
        r  = zr >>> SH;
        if (zero_flag)
        begin
            res = '0;
        end
        else if (r > ZR_W'(POS_LIM))
        begin
            res = ANG_W'(POS_LIM);
        end
        else if (r < -ZR_W'(NEG_LIM))
        begin
            res = ANG_W'(-NEG_LIM);
        end
        else
        begin
            res = r[ANG_W-1:0];
        end
        return res;
    endfunction

    assign sum_roll  = {1'b0, q_head.sq_y} + {1'b0, q_head.sq_z};
    assign sum_pitch = {1'b0, q_head.sq_x} + {1'b0, q_head.sq_z};
    assign sum_all   = {2'b00, q_head.sq_x} + {2'b00, q_head.sq_y} + {2'b00, q_head.sq_z};

    // prep stage: radicands for the three roots
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_roll_reg     <= RAD_W'(sum_pitch) << Z_FRAC;
            rad_pitch_reg    <= RAD_W'(sum_roll) << Z_FRAC;
            rad_mag_reg      <= RAD_W'(sum_all) << {range_sel, 1'b0};
            num_roll_reg[0]  <= q_head.raw_y;
            num_pitch_reg[0] <= q_head.raw_x;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= SQRT_LAT; k++)
        begin : g_num
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    num_roll_reg[k]  <= num_roll_reg[k-1];
                    num_pitch_reg[k] <= num_pitch_reg[k-1];
                end
            end
        end
        for (k = 0; k < CORDIC_STEPS; k++)
        begin : g_mag
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    mag_dly_reg[k] <= (k == 0) ? mag_root : mag_dly_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    atm_sqrt u_sqrt_roll
    (
        .clk  (clk),
        .en   (adv),
        .rad  (rad_roll_reg),
        .root (den_roll)
    );

    atm_sqrt u_sqrt_pitch
    (
        .clk  (clk),
        .en   (adv),
        .rad  (rad_pitch_reg),
        .root (den_pitch)
    );

    atm_sqrt u_sqrt_mag
    (
        .clk  (clk),
        .en   (adv),
        .rad  (rad_mag_reg),
        .root (mag_root)
    );

    atm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_roll
    (
        .clk   (clk),
        .en    (adv),
        .den   (den_roll),
        .num   (num_roll_reg[SQRT_LAT]),
        .angle (z_roll),
        .zero  (zero_roll)
    );

    atm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_pitch
    (
        .clk   (clk),
        .en    (adv),
        .den   (den_pitch),
        .num   (num_pitch_reg[SQRT_LAT]),
        .angle (z_pitch),
        .zero  (zero_pitch)
    );

    always_comb
    begin
        roll_next  = finish_angle(z_roll, zero_roll);
        pitch_next = finish_angle(z_pitch, zero_pitch);
        if (mag_dly_reg[CORDIC_STEPS-1] > ROOT_W'(MAG_MAX))
        begin
            mag_next = MAG_W'(MAG_MAX);
        end
        else
        begin
            mag_next = mag_dly_reg[CORDIC_STEPS-1][MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            mag_reg   <= mag_next;
        end
    end

    generate
        for (k = 0; k < PIPE_LEN; k++)
        begin : g_vld
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    vld_reg[k] <= (k == 0) ? !q_empty : vld_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[PIPE_LEN-1];
        end
    end

    assign roll_deg        = roll_reg;
    assign pitch_deg       = pitch_reg;
    assign accel_magnitude = mag_reg;

endmodule

### tb/accel_tilt_and_magnitude_unit_checker.sv
// ----------------------------------------------------------------------------
// accel_tilt_and_magnitude_unit_checker
// watches input and result beats, predicts roll, pitch and magnitude, compares
// ----------------------------------------------------------------------------
module accel_tilt_and_magnitude_unit_checker
#(
    parameter int CORDIC_STEPS    = atm_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = atm_pkg::DEF_ANGLE_FRAC_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [atm_pkg::RANGE_W-1:0]      cfg_data,
    input  logic                             push,
    input  logic                             full,
    input  logic signed [atm_pkg::RAW_W-1:0] raw_x,
    input  logic signed [atm_pkg::RAW_W-1:0] raw_y,
    input  logic signed [atm_pkg::RAW_W-1:0] raw_z,
    input  logic                             pop,
    input  logic                             empty,
    input  logic signed [atm_pkg::ANG_W-1:0] roll_deg,
    input  logic signed [atm_pkg::ANG_W-1:0] pitch_deg,
    input  logic [atm_pkg::MAG_W-1:0]        accel_magnitude,
    output int                               error_count,
    output int                               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic [18:0]        mag;
    } tilt_result_t;

    localparam longint ARCTAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
    };

    tilt_result_t   expected_results[$];
    logic [1:0]     range_sel;

    // rounded-to-nearest integer root
    function automatic longint round_root(longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        if (v - lo * lo > lo) lo++;
        return lo;
    endfunction

    // atan2(num, sqrt(a^2+b^2)) in degrees
    function automatic logic signed [15:0] tilt_angle(longint num, longint a, longint b);
        longint cx, cy, cz, sx, sy, r, lim;
        int     sh;
        cx = round_root((a * a + b * b) << 16);
        cy = num * 256;
        cz = 0;
        if (cx == 0 && cy == 0) return '0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy >= 0)
            begin
                cx += sy; cy -= sx; cz += ARCTAN_Q16[i];
            end
            else
            begin
                cx -= sy; cy += sx; cz -= ARCTAN_Q16[i];
            end
        end
        sh = 16 - ANGLE_FRAC_BITS;
        if (sh > 0) r = (cz + (longint'(1) << (sh - 1))) >>> sh;
        else r = cz * (longint'(1) << (-sh));
        lim = longint'(90) << ANGLE_FRAC_BITS;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        longint       x, y, z, m;
        tilt_result_t t;
        if (!rst_n)
        begin
            range_sel = '0;
            expected_results.delete();
            error_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected beat", 1, 0);
                else
                begin
                    t = expected_results.pop_front();
                    if (roll_deg !== t.roll) report_mismatch("roll_deg", roll_deg, t.roll);
                    if (pitch_deg !== t.pitch) report_mismatch("pitch_deg", pitch_deg, t.pitch);
                    if (accel_magnitude !== t.mag)
                        report_mismatch("accel_magnitude", accel_magnitude, t.mag);
                end
            end
            if (push && !full)
            begin
                x = raw_x;
                y = raw_y;
                z = raw_z;
                m = round_root((x * x + y * y + z * z) << (2 * range_sel));
                if (m > 524287) m = 524287;
                t.roll  = tilt_angle(y, x, z);
                t.pitch = tilt_angle(x, y, z);
                t.mag   = m[18:0];
                expected_results.push_back(t);
            end
            if (cfg_we) range_sel = cfg_data;
        end
    end
endmodule

### tb/accel_tilt_and_magnitude_unit_tb.sv
// ----------------------------------------------------------------------------
// accel_tilt_and_magnitude_unit_tb
// drives directed and random samples through the block under random stalls
// ----------------------------------------------------------------------------
module accel_tilt_and_magnitude_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_data = '0;
    logic               push = 1'b0;
    logic               full, empty;
    logic signed [15:0] raw_x = '0, raw_y = '0, raw_z = '0;
    logic               pop = 1'b0;
    logic signed [15:0] roll_deg, pitch_deg;
    logic [18:0]        accel_magnitude;
    int                 error_count, pending_count;
    int                 send_idle_pct = 0, take_idle_pct = 0;
    longint             cycle_count = 0;

    accel_tilt_and_magnitude_unit uut (.*);
    accel_tilt_and_magnitude_unit_checker chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("accel_tilt_and_magnitude_unit_tb: done, errors");
            $finish;
        end
    end

    // receiver side
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= take_idle_pct);

    // push stays high after the beat so the next sample can follow directly
    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push  <= 1'b1;
        raw_x <= x;
        raw_y <= y;
        raw_z <= z;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_and_set_range(logic [1:0] r);
        push <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= r;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return 16'($urandom_range(255) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] corner [5];
        corner = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        drain_and_set_range(2'd3);
        // zero vector, pure axes (zero denominator), full-scale corners
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7fff, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h7fff, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        for (int i = 0; i < 12; i++)
            send_sample(corner[$urandom_range(4)], corner[$urandom_range(4)],
                        corner[$urandom_range(4)]);
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 23 : (p == 1) ? 58 : 0;
            take_idle_pct = (p == 0) ? 58 : (p == 1) ? 23 : 0;
            for (int r = 0; r < 4; r++)
            begin
                drain_and_set_range(2'(p + r));
                for (int i = 0; i < 140; i++)
                    send_sample(pick_axis(), pick_axis(), pick_axis());
            end
        end
        push <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (error_count == 0)
            $display("accel_tilt_and_magnitude_unit_tb: done, clean");
        else
            $display("accel_tilt_and_magnitude_unit_tb: done, errors");
        $finish;
    end
endmodule
